// ===== hdl/periodic_timer_delta_queue_top_defines.svh =====
// Assertion macros for the periodic timer delta queue.
// Used by the top level; needs clk_i and rst_ni in the including scope.
`ifndef PERIODIC_TIMER_DELTA_QUEUE_TOP_DEFINES_SVH
`define PERIODIC_TIMER_DELTA_QUEUE_TOP_DEFINES_SVH
`ifndef SYNTH
// Checks a property on every clock edge outside reset.
`define PTDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks that a condition seen on one edge implies another on the next edge.
`define PTDQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define PTDQ_ASSERT(lbl, prop, msg)
`define PTDQ_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== hdl/ptdq_pkg.sv =====
// Shared constants for the periodic timer delta queue.
// No dependencies.
`timescale 1ns / 1ps
package ptdq_pkg;
  localparam int unsigned NumTimersDefault  = 16;
  localparam int unsigned PeriodBitsDefault = 16;
  localparam int unsigned TpmW   = 10;
  localparam int unsigned DeltaW = 32;

  // Operation codes.
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_CREATE = 3'd1;
  localparam logic [2:0] OP_START  = 3'd2;
  localparam logic [2:0] OP_STOP   = 3'd3;
  localparam logic [2:0] OP_DELETE = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOALLOC = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;
endpackage

// ===== hdl/ptdq_cmd_if.sv =====
// Command channel interface of the timer queue.
// No dependencies.
`timescale 1ns / 1ps
interface ptdq_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [3:0]  timer_id;
  logic [15:0] period_ms;
  modport source (output valid, opcode, timer_id, period_ms, input ready);
  modport sink (input valid, opcode, timer_id, period_ms, output ready);
endinterface

// ===== hdl/ptdq_rsp_if.sv =====
// Response channel interface of the timer queue.
// No dependencies.
`timescale 1ns / 1ps
interface ptdq_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] slot_id;
  logic       expired;
  modport source (output valid, status, slot_id, expired, input ready);
  modport sink (input valid, status, slot_id, expired, output ready);
endinterface

// ===== hdl/ptdq_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module ptdq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== hdl/ptdq_alloc.sv =====
// Lowest-free-slot finder over the allocation bits.
// No dependencies.
`timescale 1ns / 1ps
module ptdq_alloc #(
  parameter int unsigned NumTimers = 16
) (
  input  logic [NumTimers-1:0]         alloc_i,
  output logic                         found_o,
  output logic [$clog2(NumTimers)-1:0] idx_o
);
  localparam int unsigned IdxW = $clog2(NumTimers);

  // Scan from the top so the lowest free slot wins.
  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int i = NumTimers - 1; i >= 0; i--) begin
      if (!alloc_i[i]) begin
        found_o = 1'b1;
        idx_o   = IdxW'(i);
      end
    end
  end
endmodule

// ===== hdl/periodic_timer_delta_queue_top.sv =====
// Periodic timer pool kept as a delta list in a node RAM.
// Create and plain commands need no list walk; an insertion reads and scales the period and
// then walks the list entry by entry to its place, and starting, stopping or deleting an
// active timer first walks the list to unlink it. One command is processed at a time.
// The response register frees the input side while a beat waits.
// Reset (async, active low) empties the list and frees all slots; RAMs are not cleared.
`timescale 1ns / 1ps
`include "periodic_timer_delta_queue_top_defines.svh"
module periodic_timer_delta_queue_top #(
  parameter int unsigned NumTimers  = ptdq_pkg::NumTimersDefault,
  parameter int unsigned PeriodBits = ptdq_pkg::PeriodBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [ptdq_pkg::TpmW-1:0] cfg_wdata_i,
  ptdq_cmd_if.sink              cmd_i,
  ptdq_rsp_if.source            rsp_o
);
  import ptdq_pkg::*;

  localparam int unsigned IdxW  = $clog2(NumTimers);
  localparam int unsigned PtrW  = IdxW + 1;
  localparam int unsigned NodeW = PtrW + DeltaW;
  localparam int unsigned ProdW = PeriodBits + TpmW;
  localparam logic [PtrW-1:0] Nil = PtrW'(NumTimers);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_TICK     = 4'd1;
  localparam logic [3:0] S_UL_RD    = 4'd2;
  localparam logic [3:0] S_UL_NX    = 4'd3;
  localparam logic [3:0] S_UL_CLR   = 4'd4;
  localparam logic [3:0] S_AFTER    = 4'd5;
  localparam logic [3:0] S_INS0     = 4'd6;
  localparam logic [3:0] S_INS1     = 4'd7;
  localparam logic [3:0] S_INS2     = 4'd8;
  localparam logic [3:0] S_INS_HD   = 4'd9;
  localparam logic [3:0] S_INS_STEP = 4'd10;
  localparam logic [3:0] S_INS_CMP  = 4'd11;
  localparam logic [3:0] S_INS_WC   = 4'd12;
  localparam logic [3:0] S_INS_WS   = 4'd13;
  localparam logic [3:0] S_RESP     = 4'd14;

  logic [3:0]           state_q, state_d;
  logic [PtrW-1:0]      head_q, head_d;
  logic [DeltaW-1:0]    elapsed_q, elapsed_d;
  logic [TpmW-1:0]      tpm_q;
  logic [NumTimers-1:0] alloc_q, alloc_d, active_q, active_d;
  logic [2:0]           op_q, op_d;
  logic [IdxW-1:0]      id_q, id_d;
  logic [PtrW-1:0]      cur_q, cur_d, prev_q, prev_d, tmp_q, tmp_d;
  logic [DeltaW-1:0]    prev_dl_q, prev_dl_d, cur_dl_q, cur_dl_d, d_q, d_d;
  logic [ProdW-1:0]     prod_q, prod_d;
  logic [1:0]           res_st_q, res_st_d;
  logic [3:0]           res_slot_q, res_slot_d;
  logic                 res_exp_q, res_exp_d;
  logic                 out_valid_q, out_valid_d;
  logic [1:0]           out_st_q, out_st_d;
  logic [3:0]           out_slot_q, out_slot_d;
  logic                 out_exp_q, out_exp_d;

  // RAM ports.
  logic                  nd_we, pr_we;
  logic [IdxW-1:0]       nd_waddr, nd_raddr, pr_waddr, pr_raddr;
  logic [NodeW-1:0]      nd_wdata, nd_rdata;
  logic [PeriodBits-1:0] pr_wdata, pr_rdata;
  logic [PtrW-1:0]       nd_next;
  logic [DeltaW-1:0]     nd_delta;

  logic                  free_found;
  logic [IdxW-1:0]       free_idx;
  logic [PeriodBits-1:0] per;
  logic                  id_ok;
  logic [IdxW-1:0]       in_idx;
  logic [DeltaW:0]       sum;
  logic [63:0]           prod64;
  logic [DeltaW-1:0]     dsat;

  ptdq_ram #(.Width(NodeW), .Depth(NumTimers)) u_node_ram (
    .clk_i, .we_i(nd_we), .waddr_i(nd_waddr), .wdata_i(nd_wdata),
    .raddr_i(nd_raddr), .rdata_o(nd_rdata)
  );

  ptdq_ram #(.Width(PeriodBits), .Depth(NumTimers)) u_period_ram (
    .clk_i, .we_i(pr_we), .waddr_i(pr_waddr), .wdata_i(pr_wdata),
    .raddr_i(pr_raddr), .rdata_o(pr_rdata)
  );

  ptdq_alloc #(.NumTimers(NumTimers)) u_alloc (
    .alloc_i(alloc_q), .found_o(free_found), .idx_o(free_idx)
  );

  assign nd_next  = nd_rdata[NodeW-1 -: PtrW];
  assign nd_delta = nd_rdata[DeltaW-1:0];
  assign per      = PeriodBits'(cmd_i.period_ms);
  assign id_ok    = 32'(cmd_i.timer_id) < NumTimers;
  assign in_idx   = IdxW'(cmd_i.timer_id);
  assign sum      = {1'b0, nd_delta} + {1'b0, cur_dl_q};
  assign prod64   = 64'(prod_q);
  assign dsat     = (prod64 > 64'hFFFF_FFFF) ? '1 : prod64[DeltaW-1:0];

  assign cmd_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.status  = out_st_q;
  assign rsp_o.slot_id = out_slot_q;
  assign rsp_o.expired = out_exp_q;

  // Command sequencer: walks the delta list through the node RAM.
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    elapsed_d  = elapsed_q;
    alloc_d    = alloc_q;
    active_d   = active_q;
    op_d       = op_q;
    id_d       = id_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    tmp_d      = tmp_q;
    prev_dl_d  = prev_dl_q;
    cur_dl_d   = cur_dl_q;
    d_d        = d_q;
    prod_d     = prod_q;
    res_st_d   = res_st_q;
    res_slot_d = res_slot_q;
    res_exp_d  = res_exp_q;
    out_valid_d = out_valid_q & ~rsp_o.ready;
    out_st_d   = out_st_q;
    out_slot_d = out_slot_q;
    out_exp_d  = out_exp_q;
    nd_we      = 1'b0;
    nd_waddr   = id_q;
    nd_wdata   = '0;
    nd_raddr   = head_q[IdxW-1:0];
    pr_we      = 1'b0;
    pr_waddr   = free_idx;
    pr_wdata   = per;
    pr_raddr   = id_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          op_d       = cmd_i.opcode;
          id_d       = in_idx;
          res_st_d   = ST_OK;
          res_slot_d = '0;
          res_exp_d  = 1'b0;
          state_d    = S_RESP;
          case (cmd_i.opcode)
            OP_TICK: begin
              if (head_q != Nil) begin
                elapsed_d = elapsed_q + 1'b1;
                state_d   = S_TICK;
              end
            end
            OP_CREATE: begin
              if (per == '0) begin
                res_st_d = ST_ZERO;
              end else if (!free_found) begin
                res_st_d = ST_FULL;
              end else begin
                pr_we             = 1'b1;
                alloc_d[free_idx] = 1'b1;
                active_d[free_idx] = 1'b0;
                res_slot_d        = 4'(free_idx);
              end
            end
            OP_START, OP_STOP, OP_DELETE: begin
              if (!id_ok || !alloc_q[in_idx]) begin
                res_st_d = ST_NOALLOC;
              end else if (active_q[in_idx]) begin
                prev_d  = Nil;
                cur_d   = head_q;
                state_d = S_UL_RD;
              end else begin
                state_d = S_AFTER;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      // Head entry data is here: check for expiry.
      S_TICK: begin
        if (nd_delta <= elapsed_q) begin
          elapsed_d  = '0;
          id_d       = head_q[IdxW-1:0];
          active_d[head_q[IdxW-1:0]] = 1'b0;
          head_d     = nd_next;
          res_slot_d = 4'(head_q[IdxW-1:0]);
          res_exp_d  = 1'b1;
          state_d    = S_INS0;
        end else begin
          state_d = S_RESP;
        end
      end
      // Unlink walk: node of cur_q is on the read port.
      S_UL_RD: begin
        if (cur_q == PtrW'(id_q)) begin
          if (prev_q == Nil) begin
            head_d = nd_next;
          end else begin
            nd_we    = 1'b1;
            nd_waddr = prev_q[IdxW-1:0];
            nd_wdata = {nd_next, prev_dl_q};
          end
          cur_dl_d     = nd_delta;
          active_d[id_q] = 1'b0;
          tmp_d        = nd_next;
          nd_raddr     = nd_next[IdxW-1:0];
          state_d      = (nd_next != Nil) ? S_UL_NX : S_UL_CLR;
        end else begin
          prev_d    = cur_q;
          prev_dl_d = nd_delta;
          cur_d     = nd_next;
          nd_raddr  = nd_next[IdxW-1:0];
          if (nd_next == Nil) begin
            active_d[id_q] = 1'b0;
            state_d        = S_AFTER;
          end
        end
      end
      // The follower inherits the removed delay, saturated.
      S_UL_NX: begin
        nd_we    = 1'b1;
        nd_waddr = tmp_q[IdxW-1:0];
        nd_wdata = {nd_next, sum[DeltaW] ? {DeltaW{1'b1}} : sum[DeltaW-1:0]};
        state_d  = S_UL_CLR;
      end
      S_UL_CLR: begin
        nd_we    = 1'b1;
        nd_wdata = {Nil, cur_dl_q};
        state_d  = S_AFTER;
      end
      S_AFTER: begin
        case (op_q)
          OP_START: begin
            state_d = S_INS0;
          end
          OP_DELETE: begin
            alloc_d[id_q] = 1'b0;
            state_d       = S_RESP;
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end
      // Insertion: fetch the period and scale it.
      S_INS0: begin
        state_d = S_INS1;
      end
      S_INS1: begin
        prod_d  = ProdW'(pr_rdata) * ProdW'(tpm_q);
        state_d = S_INS2;
      end
      S_INS2: begin
        active_d[id_q] = 1'b1;
        if (head_q == Nil) begin
          nd_we    = 1'b1;
          nd_wdata = {Nil, dsat};
          head_d   = PtrW'(id_q);
          state_d  = S_RESP;
        end else begin
          d_d     = dsat;
          cur_d   = head_q;
          state_d = S_INS_HD;
        end
      end
      S_INS_HD: begin
        if (nd_delta > d_q) begin
          nd_we    = 1'b1;
          nd_waddr = cur_q[IdxW-1:0];
          nd_wdata = {nd_next, nd_delta - d_q};
          tmp_d    = cur_q;
          head_d   = PtrW'(id_q);
          state_d  = S_INS_WS;
        end else begin
          d_d      = d_q - nd_delta;
          cur_dl_d = nd_delta;
          tmp_d    = nd_next;
          state_d  = S_INS_STEP;
        end
      end
      // tmp_q is the successor of cur_q; d_q is relative to cur_q.
      S_INS_STEP: begin
        if (tmp_q == Nil) begin
          nd_we    = 1'b1;
          nd_waddr = cur_q[IdxW-1:0];
          nd_wdata = {PtrW'(id_q), cur_dl_q};
          state_d  = S_INS_WS;
        end else begin
          nd_raddr = tmp_q[IdxW-1:0];
          state_d  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (nd_delta > d_q) begin
          nd_we    = 1'b1;
          nd_waddr = tmp_q[IdxW-1:0];
          nd_wdata = {nd_next, nd_delta - d_q};
          state_d  = S_INS_WC;
        end else begin
          d_d      = d_q - nd_delta;
          cur_d    = tmp_q;
          cur_dl_d = nd_delta;
          tmp_d    = nd_next;
          state_d  = S_INS_STEP;
        end
      end
      S_INS_WC: begin
        nd_we    = 1'b1;
        nd_waddr = cur_q[IdxW-1:0];
        nd_wdata = {PtrW'(id_q), cur_dl_q};
        state_d  = S_INS_WS;
      end
      S_INS_WS: begin
        nd_we    = 1'b1;
        nd_wdata = {tmp_q, d_q};
        state_d  = S_RESP;
      end
      // Hand the result to the response register once it is free.
      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_slot_d  = res_slot_q;
          out_exp_d   = res_exp_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= Nil;
      elapsed_q   <= '0;
      tpm_q       <= TpmW'(1);
      alloc_q     <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      elapsed_q   <= elapsed_d;
      alloc_q     <= alloc_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        tpm_q <= cfg_wdata_i;
      end
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    id_q       <= id_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    tmp_q      <= tmp_d;
    prev_dl_q  <= prev_dl_d;
    cur_dl_q   <= cur_dl_d;
    d_q        <= d_d;
    prod_q     <= prod_d;
    res_st_q   <= res_st_d;
    res_slot_q <= res_slot_d;
    res_exp_q  <= res_exp_d;
    out_st_q   <= out_st_d;
    out_slot_q <= out_slot_d;
    out_exp_q  <= out_exp_d;
  end

  // Assertions.
  `PTDQ_ASSERT(a_active_alloc, (active_q & ~alloc_q) == '0, "active slot not allocated")
  `PTDQ_ASSERT(a_empty_idle, !(state_q == S_IDLE && head_q == Nil) || active_q == '0, "empty list with active slot")
  `PTDQ_ASSERT_NEXT(a_exp_ok, state_q == S_RESP && res_exp_q && (!out_valid_q || rsp_o.ready), out_valid_q && out_st_q == ST_OK, "expiry with bad status")
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the periodic timer delta queue.
// Depends on ptdq_pkg, ptdq_cmd_if, ptdq_rsp_if and periodic_timer_delta_queue_top.
`timescale 1ns / 1ps
module testbench;
  import ptdq_pkg::*;

  localparam int unsigned Slots     = 16;
  localparam int unsigned NoSlot    = Slots;
  localparam int unsigned SettleCyc = 60;
  localparam int unsigned StallMax  = 5000;
  localparam logic [2:0]  OP_FIRST_UNUSED = OP_DELETE + 3'd1;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot_id;
    logic       expired;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [TpmW-1:0] cfg_wdata_i = '0;

  ptdq_cmd_if cmd ();
  ptdq_rsp_if rsp ();

  periodic_timer_delta_queue_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd.sink),
    .rsp_o       (rsp.source)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Timer pool mirror used to predict replies.
  logic             pool_alloc [Slots];
  logic             pool_run   [Slots];
  logic [15:0]      pool_per   [Slots];
  logic [31:0]      pool_delta [Slots];
  int unsigned      pool_next  [Slots];
  int unsigned      run_head;
  logic [31:0]      tick_count;
  logic [TpmW-1:0]  tick_rate;

  reply_t      pending_replies[$];
  int          errors;
  int          n_sent;
  int          n_expiries;
  int          n_checked;
  bit          calm;
  int unsigned stall_cycles;

  function automatic logic [31:0] scaled_wait(int unsigned s);
    logic [63:0] p;
    p = 64'(pool_per[s]) * 64'(tick_rate);
    return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  // Removes a slot from the run list, handing its delay on to its follower.
  function automatic void unlink_timer(int unsigned s);
    int unsigned prev, cur, nx;
    logic [32:0] sum;
    prev = NoSlot;
    cur  = run_head;
    for (int n = 0; n < Slots && cur < NoSlot; n++) begin
      if (cur == s) begin
        nx = pool_next[cur];
        if (prev == NoSlot) run_head = nx;
        else pool_next[prev] = nx;
        if (nx < NoSlot) begin
          sum = 33'(pool_delta[nx]) + 33'(pool_delta[cur]);
          pool_delta[nx] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        pool_next[cur] = NoSlot;
        break;
      end
      prev = cur;
      cur  = pool_next[cur];
    end
    pool_run[s] = 1'b0;
  endfunction

  // Inserts a slot in expiry order; equal delays go after existing entries.
  function automatic void insert_timer(int unsigned s);
    logic [31:0] d;
    int unsigned cur, nx;
    d = scaled_wait(s);
    pool_next[s] = NoSlot;
    pool_run[s]  = 1'b1;
    if (run_head >= NoSlot) begin
      pool_delta[s] = d;
      run_head = s;
      return;
    end
    if (pool_delta[run_head] > d) begin
      pool_delta[run_head] -= d;
      pool_delta[s] = d;
      pool_next[s]  = run_head;
      run_head = s;
      return;
    end
    cur = run_head;
    for (int n = 0; n < Slots && cur < NoSlot; n++) begin
      nx = pool_next[cur];
      d -= pool_delta[cur];
      if (nx >= NoSlot || pool_delta[nx] > d) begin
        if (nx < NoSlot) pool_delta[nx] -= d;
        pool_delta[s]  = d;
        pool_next[s]   = nx;
        pool_next[cur] = s;
        return;
      end
      cur = nx;
    end
    pool_delta[s] = d;
  endfunction

  function automatic reply_t apply_command(logic [2:0] op, logic [3:0] id, logic [15:0] per);
    reply_t r;
    int unsigned h;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_TICK: begin
        if (run_head < NoSlot) begin
          tick_count += 32'd1;
          if (pool_delta[run_head] <= tick_count) begin
            h = run_head;
            tick_count = '0;
            pool_delta[h] = '0;
            unlink_timer(h);
            insert_timer(h);
            r.slot_id = h[3:0];
            r.expired = 1'b1;
          end
        end
      end
      OP_CREATE: begin
        if (per == '0) begin
          r.status = ST_ZERO;
        end else begin
          r.status = ST_FULL;
          for (int i = 0; i < Slots; i++) begin
            if (!pool_alloc[i]) begin
              pool_alloc[i] = 1'b1;
              pool_run[i]   = 1'b0;
              pool_per[i]   = per;
              pool_next[i]  = NoSlot;
              pool_delta[i] = scaled_wait(i);
              r.status  = ST_OK;
              r.slot_id = i[3:0];
              break;
            end
          end
        end
      end
      OP_START, OP_STOP, OP_DELETE: begin
        if (!pool_alloc[id]) begin
          r.status = ST_NOALLOC;
        end else begin
          if (pool_run[id]) unlink_timer(id);
          if (op == OP_START) insert_timer(id);
          else if (op == OP_DELETE) pool_alloc[id] = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Sends one command beat and records the reply it should produce.
  task automatic send_command(logic [2:0] op, logic [3:0] id, logic [15:0] per);
    while (!calm && $urandom_range(0, 99) < 16) begin
      @(negedge clk_i);
      cmd.valid = 1'b0;
    end
    @(negedge clk_i);
    cmd.valid     = 1'b1;
    cmd.opcode    = op;
    cmd.timer_id  = id;
    cmd.period_ms = per;
    do @(posedge clk_i); while (!cmd.ready);
    pending_replies.push_back(apply_command(op, id, per));
    n_sent++;
    @(negedge clk_i);
    cmd.valid = 1'b0;
  endtask

  // Writes the tick rate once the block has drained.
  task automatic set_tick_rate(logic [TpmW-1:0] v);
    wait (pending_replies.size() == 0);
    repeat (SettleCyc) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    tick_rate   = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Random receiver stalls, driven on the falling edge.
  always @(negedge clk_i) begin
    rsp.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 16);
  end

  // Compares every reply beat against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_replies.size() == 0) begin
        $error("reply beat with nothing expected");
        errors++;
      end else begin
        reply_t e;
        e = pending_replies.pop_front();
        n_checked++;
        if (e.expired) n_expiries++;
        if (rsp.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, rsp.status);
          errors++;
        end
        if (rsp.slot_id !== e.slot_id) begin
          $error("slot_id: expected %0d, got %0d", e.slot_id, rsp.slot_id);
          errors++;
        end
        if (rsp.expired !== e.expired) begin
          $error("expired: expected %0d, got %0d", e.expired, rsp.expired);
          errors++;
        end
      end
    end
  end

  // Ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallMax) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic test_basic_ops();
    send_command(OP_TICK, 4'd0, 16'd0);
    send_command(OP_CREATE, 4'd0, 16'd0);
    send_command(OP_CREATE, 4'd0, 16'hFFFF);
    send_command(OP_CREATE, 4'hF, 16'd1);
    send_command(OP_CREATE, 4'd0, 16'd2);
    send_command(OP_START, 4'hF, 16'd0);
    send_command(OP_STOP, 4'd1, 16'd0);
    send_command(OP_START, 4'd0, 16'd0);
    send_command(OP_START, 4'd1, 16'd0);
    send_command(OP_START, 4'd2, 16'd0);
    repeat (4) send_command(OP_TICK, 4'd0, 16'd0);
    send_command(OP_START, 4'd1, 16'd0);
    send_command(OP_STOP, 4'd1, 16'd0);
    send_command(OP_TICK, 4'd0, 16'd0);
    send_command(OP_DELETE, 4'd2, 16'd0);
    send_command(OP_DELETE, 4'd2, 16'd0);
    for (int op = OP_FIRST_UNUSED; op <= 7; op++) send_command(op[2:0], 4'hA, 16'hFFFF);
  endtask

  // Fills the pool until a create is refused, then frees every slot.
  task automatic test_full_pool();
    for (int i = 0; i < Slots; i++) send_command(OP_CREATE, 4'd0, 16'd3);
    for (int i = 0; i < Slots; i++) send_command(OP_DELETE, i[3:0], 16'd0);
  endtask

  task automatic test_rate_extremes();
    set_tick_rate(10'd1000);
    send_command(OP_CREATE, 4'd0, 16'hFFFF);
    send_command(OP_CREATE, 4'd0, 16'd1);
    send_command(OP_START, 4'd0, 16'd0);
    send_command(OP_START, 4'd1, 16'd0);
    repeat (3) send_command(OP_TICK, 4'd0, 16'd0);
    send_command(OP_DELETE, 4'd0, 16'd0);
    send_command(OP_DELETE, 4'd1, 16'd0);
    set_tick_rate(10'd1);
  endtask

  // Mostly short periods so that expiries happen often; some full-range noise.
  // Where a run reaches it, the second block of up to 200 commands always runs without any idling.
  task automatic test_random_traffic(int count);
    int unsigned pick;
    logic [15:0] per;
    for (int k = 0; k < count; k++) begin
      if (k % 200 == 0) calm = ($urandom_range(0, 3) == 0) || (k == 200);
      pick = $urandom_range(0, 99);
      per  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 9));
      if (pick < 45) send_command(OP_TICK, 4'($urandom), 16'($urandom));
      else if (pick < 60) send_command(OP_CREATE, 4'($urandom), per);
      else if (pick < 78) send_command(OP_START, 4'($urandom), 16'($urandom));
      else if (pick < 88) send_command(OP_STOP, 4'($urandom), 16'($urandom));
      else if (pick < 97) send_command(OP_DELETE, 4'($urandom), 16'($urandom));
      else send_command(3'($urandom_range(OP_FIRST_UNUSED, 7)), 4'($urandom), 16'($urandom));
    end
    calm = 1'b0;
  endtask

  initial begin
    errors = 0;
    n_sent = 0;
    n_expiries = 0;
    n_checked = 0;
    calm = 1'b0;
    stall_cycles = 0;
    cmd.valid = 1'b0;
    cmd.opcode = OP_TICK;
    cmd.timer_id = '0;
    cmd.period_ms = '0;
    rsp.ready = 1'b0;
    for (int i = 0; i < Slots; i++) begin
      pool_alloc[i] = 1'b0;
      pool_run[i]   = 1'b0;
      pool_per[i]   = '0;
      pool_delta[i] = '0;
      pool_next[i]  = NoSlot;
    end
    run_head   = NoSlot;
    tick_count = '0;
    tick_rate  = 10'd1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_tick_rate(10'd1);
    test_basic_ops();
    test_full_pool();
    test_rate_extremes();
    test_random_traffic(800);
    set_tick_rate(10'd2);
    test_random_traffic(400);
    set_tick_rate(10'd1000);
    test_random_traffic(150);
    set_tick_rate(10'd1);
    test_random_traffic(300);

    wait (pending_replies.size() == 0);
    repeat (SettleCyc) @(posedge clk_i);
    $display("tb: %0d commands sent, %0d replies checked, %0d timer expiries seen",
             n_sent, n_checked, n_expiries);
    $display("tb: tick rates 1, 2 and 1000 exercised with random stalls on both sides");
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
